// ----- rtl/core/fem_pkg.sv -----
// feathered ellipse mask: shared constants, register codes and pipeline records
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fem_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W  = 12;
    localparam int BOX_W  = 13;
    localparam int FTH_W  = 12;
    localparam int MASK_W = 8;
    localparam int IDX_W  = 3;

    // quotient, root and scale chain lengths
    localparam int QN = 17;
    localparam int RN = 9;
    localparam int SN = 8;

    typedef enum logic [IDX_W-1:0] {
        REG_BOX_LEFT   = 3'd0,
        REG_BOX_TOP    = 3'd1,
        REG_BOX_RIGHT  = 3'd2,
        REG_BOX_BOTTOM = 3'd3,
        REG_FEATHER    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [BOX_W-1:0] box_left;
        logic [BOX_W-1:0] box_top;
        logic [BOX_W-1:0] box_right;
        logic [BOX_W-1:0] box_bottom;
        logic [FTH_W-1:0] feather;
    } t_cfg;

    // radial quotient and feather quotient, one bit per cell
    typedef struct packed {
        logic        valid;
        logic        in_ell;
        logic [48:0] rem;
        logic [47:0] edge_v;
        logic [16:0] quo;
        logic [12:0] frem;
        logic [11:0] minr;
        logic [16:0] fquo;
    } t_qd;

    // floor square root, two radicand bits per cell
    typedef struct packed {
        logic        valid;
        logic        in_ell;
        logic [8:0]  fn;
        logic [17:0] rad;
        logic [10:0] rem;
        logic [8:0]  root;
    } t_rd;

    // ramp scale division, one bit per cell
    typedef struct packed {
        logic        valid;
        logic        in_ell;
        logic        ramp;
        logic [8:0]  fn;
        logic [8:0]  rem;
        logic [7:0]  nlo;
        logic [7:0]  quo;
    } t_sd;

endpackage

`default_nettype wire

// ----- rtl/core/fem_if.sv -----
// feathered ellipse mask: pixel and mask channel interfaces
// depends on fem_pkg
`timescale 1ns / 1ps
`default_nettype none

interface fem_in_if;
    import fem_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface fem_out_if;
    import fem_pkg::*;
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] mask_value;
    logic              inside_res;
    modport source (output valid, output mask_value, output inside_res, input ready);
    modport sink (input valid, input mask_value, input inside_res, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fem_prep.sv -----
// feathered ellipse mask: six front stages, box ordering, radii, squares and the
// ellipse sum with the inside test; depends on fem_pkg
`timescale 1ns / 1ps
`default_nettype none

module fem_prep (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [fem_pkg::PIX_W-1:0]   i_px,
    input  logic [fem_pkg::PIX_W-1:0]   i_py,
    input  fem_pkg::t_cfg               i_cfg,
    output fem_pkg::t_qd                o_d
);
    import fem_pkg::*;

    // stage 1
    logic              r1_v, r1_oob;
    logic [PIX_W-1:0]  r1_px, r1_py;
    logic [BOX_W-1:0]  r1_lox, r1_loy;
    logic [13:0]       r1_extx, r1_exty;
    logic [FTH_W-1:0]  r1_fth;
    // stage 2
    logic              r2_v, r2_oob;
    logic [PIX_W-1:0]  r2_px, r2_py;
    logic [11:0]       r2_rx, r2_ry;
    logic [13:0]       r2_cx, r2_cy;
    logic [FTH_W-1:0]  r2_fth;
    // stage 3
    logic              r3_v, r3_oob;
    logic [13:0]       r3_adx, r3_ady;
    logic [11:0]       r3_rx, r3_ry, r3_minr, r3_fth;
    // stage 4
    logic              r4_v, r4_oob;
    logic [25:0]       r4_dx2, r4_dy2;
    logic [23:0]       r4_rx2, r4_ry2;
    logic [11:0]       r4_minr, r4_fth;
    // stage 5
    logic              r5_v, r5_oob;
    logic [49:0]       r5_a, r5_b;
    logic [47:0]       r5_edge;
    logic [11:0]       r5_minr, r5_fth;
    // stage 6
    t_qd               r6_d;

    logic              n1_swx, n1_swy;
    logic [BOX_W-1:0]  n1_lox, n1_hix, n1_loy, n1_hiy;
    logic [11:0]       n2_rx, n2_ry;
    logic [14:0]       n3_dx, n3_dy;
    logic [11:0]       n3_minr;
    logic [50:0]       n6_f;

    always_comb begin
        n1_swx = $signed(i_cfg.box_right) < $signed(i_cfg.box_left);
        n1_swy = $signed(i_cfg.box_bottom) < $signed(i_cfg.box_top);
        n1_lox = n1_swx ? i_cfg.box_right : i_cfg.box_left;
        n1_hix = n1_swx ? i_cfg.box_left : i_cfg.box_right;
        n1_loy = n1_swy ? i_cfg.box_bottom : i_cfg.box_top;
        n1_hiy = n1_swy ? i_cfg.box_top : i_cfg.box_bottom;
        n2_rx  = (r1_extx[12:1] == 12'd0) ? 12'd1 : r1_extx[12:1];
        n2_ry  = (r1_exty[12:1] == 12'd0) ? 12'd1 : r1_exty[12:1];
        n3_dx  = {3'b000, r2_px} - {r2_cx[13], r2_cx};
        n3_dy  = {3'b000, r2_py} - {r2_cy[13], r2_cy};
        n3_minr = (r2_rx < r2_ry) ? r2_rx : r2_ry;
        n6_f   = {1'b0, r5_a} + {1'b0, r5_b};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_v    <= i_valid;
            r1_oob  <= ({1'b0, i_px} >= 13'(MAX_WIDTH)) || ({1'b0, i_py} >= 13'(MAX_HEIGHT));
            r1_px   <= i_px;
            r1_py   <= i_py;
            r1_lox  <= n1_lox;
            r1_loy  <= n1_loy;
            r1_extx <= {n1_hix[12], n1_hix} - {n1_lox[12], n1_lox};
            r1_exty <= {n1_hiy[12], n1_hiy} - {n1_loy[12], n1_loy};
            r1_fth  <= i_cfg.feather;

            r2_v    <= r1_v;
            r2_oob  <= r1_oob;
            r2_px   <= r1_px;
            r2_py   <= r1_py;
            r2_rx   <= n2_rx;
            r2_ry   <= n2_ry;
            r2_cx   <= {r1_lox[12], r1_lox} + {2'b00, n2_rx};
            r2_cy   <= {r1_loy[12], r1_loy} + {2'b00, n2_ry};
            r2_fth  <= r1_fth;

            r3_v    <= r2_v;
            r3_oob  <= r2_oob;
            r3_adx  <= n3_dx[14] ? 14'(-n3_dx) : n3_dx[13:0];
            r3_ady  <= n3_dy[14] ? 14'(-n3_dy) : n3_dy[13:0];
            r3_rx   <= r2_rx;
            r3_ry   <= r2_ry;
            r3_minr <= n3_minr;
            r3_fth  <= (r2_fth > n3_minr) ? n3_minr : r2_fth;

            r4_v    <= r3_v;
            r4_oob  <= r3_oob;
            r4_dx2  <= 26'(r3_adx) * 26'(r3_adx);
            r4_dy2  <= 26'(r3_ady) * 26'(r3_ady);
            r4_rx2  <= 24'(r3_rx) * 24'(r3_rx);
            r4_ry2  <= 24'(r3_ry) * 24'(r3_ry);
            r4_minr <= r3_minr;
            r4_fth  <= r3_fth;

            r5_v    <= r4_v;
            r5_oob  <= r4_oob;
            r5_a    <= 50'(r4_dx2) * 50'(r4_ry2);
            r5_b    <= 50'(r4_dy2) * 50'(r4_rx2);
            r5_edge <= 48'(r4_rx2) * 48'(r4_ry2);
            r5_minr <= r4_minr;
            r5_fth  <= r4_fth;

            r6_d.valid  <= r5_v;
            r6_d.in_ell <= !r5_oob && (n6_f <= {3'b000, r5_edge});
            r6_d.rem    <= n6_f[48:0];
            r6_d.edge_v <= r5_edge;
            r6_d.quo    <= '0;
            r6_d.frem   <= {1'b0, r5_fth};
            r6_d.minr   <= r5_minr;
            r6_d.fquo   <= '0;
        end
        if (!i_rst_n) begin
            r1_v       <= 1'b0;
            r2_v       <= 1'b0;
            r3_v       <= 1'b0;
            r4_v       <= 1'b0;
            r5_v       <= 1'b0;
            r6_d.valid <= 1'b0;
        end
    end

    assign o_d = r6_d;

endmodule

`default_nettype wire

// ----- rtl/core/fem_qcell.sv -----
// feathered ellipse mask: one restoring step of the radial and feather quotients
// depends on fem_pkg
`timescale 1ns / 1ps
`default_nettype none

module fem_qcell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  fem_pkg::t_qd i_d,
    output fem_pkg::t_qd o_d
);
    import fem_pkg::*;

    t_qd  r_d, n_d;
    logic w_ge, w_fge;

    always_comb begin
        n_d   = i_d;
        w_ge  = i_d.rem >= {1'b0, i_d.edge_v};
        w_fge = i_d.frem >= {1'b0, i_d.minr};
        n_d.rem  = w_ge ? 49'((i_d.rem - {1'b0, i_d.edge_v}) << 1) : 49'(i_d.rem << 1);
        n_d.quo  = {i_d.quo[15:0], w_ge};
        n_d.frem = w_fge ? 13'((i_d.frem - {1'b0, i_d.minr}) << 1) : 13'(i_d.frem << 1);
        n_d.fquo = {i_d.fquo[15:0], w_fge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

// ----- rtl/core/fem_rcell.sv -----
// feathered ellipse mask: one digit step of the floor square root
// depends on fem_pkg
`timescale 1ns / 1ps
`default_nettype none

module fem_rcell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  fem_pkg::t_rd i_d,
    output fem_pkg::t_rd o_d
);
    import fem_pkg::*;

    t_rd         r_d, n_d;
    logic [12:0] w_t;
    logic [10:0] w_trial;
    logic        w_ge;

    always_comb begin
        n_d     = i_d;
        w_t     = {i_d.rem, i_d.rad[17:16]};
        w_trial = {i_d.root, 2'b01};
        w_ge    = w_t >= {2'b00, w_trial};
        n_d.rem  = w_ge ? 11'(w_t - {2'b00, w_trial}) : w_t[10:0];
        n_d.root = {i_d.root[7:0], w_ge};
        n_d.rad  = {i_d.rad[15:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

// ----- rtl/core/fem_scell.sv -----
// feathered ellipse mask: one restoring step of the ramp scale division
// depends on fem_pkg
`timescale 1ns / 1ps
`default_nettype none

module fem_scell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  fem_pkg::t_sd i_d,
    output fem_pkg::t_sd o_d
);
    import fem_pkg::*;

    t_sd        r_d, n_d;
    logic [9:0] w_t;
    logic       w_ge;

    always_comb begin
        n_d     = i_d;
        w_t     = {i_d.rem, i_d.nlo[7]};
        w_ge    = w_t >= {1'b0, i_d.fn};
        n_d.rem = w_ge ? 9'(w_t - {1'b0, i_d.fn}) : w_t[8:0];
        n_d.nlo = {i_d.nlo[6:0], 1'b0};
        n_d.quo = {i_d.quo[6:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

// ----- rtl/core/feathered_ellipse_mask_top.sv -----
// feathered ellipse mask top level: config registers, cell chains, output skid
// depends on fem_pkg, fem_if, fem_prep, fem_qcell, fem_rcell, fem_scell
//
// usage:
//   i_pix carries one pixel (pixel_x, pixel_y) per item; o_mask returns one item
//   per pixel with mask_value and inside_res, in the order the pixels came in.
//   the box corners and feather width are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data; the user must do so only while no item is in flight, as the block
//   does not enforce it. the pipeline has six front stages (ordering, radii,
//   squares, ellipse sum), 17 quotient cells, 9 square root cells, 8 ramp
//   division cells and the output register.
//   throughput is one item per cycle; every chain cell hands its item on each
//   cycle the pipeline moves.
//   when the receiver stalls, the output register holds and one more item lands
//   in a skid register; only then does i_pix.ready drop and the whole pipeline
//   freeze until the skid drains.
//   reset clears all valid flags, the skid and the config registers to zero.
`timescale 1ns / 1ps
`default_nettype none

module feathered_ellipse_mask_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    fem_in_if.sink                      i_pix,
    fem_out_if.source                   o_mask,
    input  logic                        i_cfg_we,
    input  logic [fem_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [fem_pkg::BOX_W-1:0]   i_cfg_data
);
    import fem_pkg::*;

    t_cfg              r_cfg;
    logic              w_en;
    t_qd               w_q [QN+1];
    t_rd               w_r [RN+1];
    t_sd               w_s [SN+1];
    logic [8:0]        w_nd, w_d9;
    logic [16:0]       w_num;
    logic [MASK_W-1:0] w_mask;
    logic              w_take;

    logic              r_out_v, r_out_in, r_skid_v, r_skid_in;
    logic [MASK_W-1:0] r_out_mask, r_skid_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_BOX_LEFT:   r_cfg.box_left   <= i_cfg_data;
                REG_BOX_TOP:    r_cfg.box_top    <= i_cfg_data;
                REG_BOX_RIGHT:  r_cfg.box_right  <= i_cfg_data;
                REG_BOX_BOTTOM: r_cfg.box_bottom <= i_cfg_data;
                REG_FEATHER:    r_cfg.feather    <= i_cfg_data[FTH_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_en        = !r_skid_v;
    assign i_pix.ready = w_en;

    fem_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_pix.valid),
        .i_px    (i_pix.pixel_x),
        .i_py    (i_pix.pixel_y),
        .i_cfg   (r_cfg),
        .o_d     (w_q[0])
    );

    for (genvar g = 0; g < QN; g++) begin : g_q
        fem_qcell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_d     (w_q[g]),
            .o_d     (w_q[g+1])
        );
    end

    always_comb begin
        w_r[0].valid  = w_q[QN].valid;
        w_r[0].in_ell = w_q[QN].in_ell;
        w_r[0].fn     = w_q[QN].fquo[16:8];
        w_r[0].rad    = {1'b0, w_q[QN].quo};
        w_r[0].rem    = '0;
        w_r[0].root   = '0;
    end

    for (genvar g = 0; g < RN; g++) begin : g_r
        fem_rcell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_d     (w_r[g]),
            .o_d     (w_r[g+1])
        );
    end

    always_comb begin
        w_nd  = w_r[RN].root;
        w_d9  = 9'(10'd256 - {1'b0, w_nd});
        w_num = {w_d9, 8'h00} - {8'h00, w_d9};
        w_s[0].valid  = w_r[RN].valid;
        w_s[0].in_ell = w_r[RN].in_ell;
        w_s[0].ramp   = (w_r[RN].fn != 9'd0)
                        && (({1'b0, w_nd} + {1'b0, w_r[RN].fn}) > 10'd256);
        w_s[0].fn     = w_r[RN].fn;
        w_s[0].rem    = {1'b0, w_num[15:8]};
        w_s[0].nlo    = w_num[7:0];
        w_s[0].quo    = '0;
    end

    for (genvar g = 0; g < SN; g++) begin : g_s
        fem_scell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_d     (w_s[g]),
            .o_d     (w_s[g+1])
        );
    end

    always_comb begin
        if (!w_s[SN].in_ell) begin
            w_mask = '0;
        end else if (w_s[SN].ramp) begin
            w_mask = w_s[SN].quo;
        end else begin
            w_mask = '1;
        end
    end

    assign w_take = !r_out_v || o_mask.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_take) begin
            if (r_skid_v) begin
                r_out_v    <= 1'b1;
                r_out_mask <= r_skid_mask;
                r_out_in   <= r_skid_in;
                r_skid_v   <= 1'b0;
            end else begin
                r_out_v    <= w_en && w_s[SN].valid;
                r_out_mask <= w_mask;
                r_out_in   <= w_s[SN].in_ell;
            end
        end else if (w_en && w_s[SN].valid) begin
            r_skid_v    <= 1'b1;
            r_skid_mask <= w_mask;
            r_skid_in   <= w_s[SN].in_ell;
        end
    end

    assign o_mask.valid      = r_out_v;
    assign o_mask.mask_value = r_out_mask;
    assign o_mask.inside_res = r_out_in;

endmodule

`default_nettype wire

// ----- dv/feathered_ellipse_mask_top_tb.sv -----
// testbench for the feathered ellipse mask: directed and random pixels over several boxes
// depends on fem_pkg, fem_if and the feathered_ellipse_mask_top rtl
`timescale 1ns / 1ps

class mask_scoreboard;
    logic [7:0] exp_mask[$];
    logic       exp_inside[$];
    int         errors;
    logic signed [12:0] bl, bt, br, bb;
    logic [11:0] fw;

    function new();
        errors = 0;
        bl = 0; bt = 0; br = 0; bb = 0; fw = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [12:0] d);
        case (idx)
            fem_pkg::REG_BOX_LEFT:   bl = d;
            fem_pkg::REG_BOX_TOP:    bt = d;
            fem_pkg::REG_BOX_RIGHT:  br = d;
            fem_pkg::REG_BOX_BOTTOM: bb = d;
            fem_pkg::REG_FEATHER:    fw = d[11:0];
            default: ;
        endcase
    endfunction

    function longint unsigned isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function void note_pixel(logic [11:0] px, logic [11:0] py);
        longint x0, y0, x1, y1, t, rx, ry, cx, cy, minr, fth, fn, dx, dy, s;
        longint unsigned f, edge_v, nd;
        logic [7:0] v;
        x0 = bl; y0 = bt; x1 = br; y1 = bb;
        if (x1 < x0) begin t = x0; x0 = x1; x1 = t; end
        if (y1 < y0) begin t = y0; y0 = y1; y1 = t; end
        rx = (x1 - x0) / 2;
        ry = (y1 - y0) / 2;
        if (rx < 1) rx = 1;
        if (ry < 1) ry = 1;
        cx = x0 + rx;
        cy = y0 + ry;
        minr = (rx < ry) ? rx : ry;
        fth = fw;
        if (fth > minr) fth = minr;
        fn = (fth > 0) ? fth * 256 / minr : 0;
        dx = longint'(px) - cx;
        dy = longint'(py) - cy;
        f = longint'(dx * dx) * (ry * ry) + longint'(dy * dy) * (rx * rx);
        edge_v = (rx * rx) * (ry * ry);
        if (f > edge_v) begin
            exp_mask.push_back(8'd0);
            exp_inside.push_back(1'b0);
            return;
        end
        v = 8'd255;
        if (fn > 0) begin
            nd = isqrt(f * 65536 / edge_v);
            if (longint'(nd) > 256 - fn) begin
                s = (256 - longint'(nd)) * 255 / fn;
                if (s < 0) s = 0;
                if (s > 255) s = 255;
                v = s[7:0];
            end
        end
        exp_mask.push_back(v);
        exp_inside.push_back(1'b1);
    endfunction

    function void check_mask(logic [7:0] m, logic ins);
        if (exp_mask.size() == 0) begin
            $display("%0t: unexpected item mask %0d inside %0d", $time, m, ins);
            errors++;
            return;
        end
        if (exp_mask[0] !== m) begin
            $display("%0t: mask_value expected %0d actual %0d", $time, exp_mask[0], m);
            errors++;
        end
        if (exp_inside[0] !== ins) begin
            $display("%0t: inside_res expected %0d actual %0d", $time, exp_inside[0], ins);
            errors++;
        end
        void'(exp_mask.pop_front());
        void'(exp_inside.pop_front());
    endfunction
endclass

module feathered_ellipse_mask_top_tb;
    import fem_pkg::*;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [BOX_W-1:0] i_cfg_data;
    fem_in_if  pix_if();
    fem_out_if mask_if();
    mask_scoreboard sb;
    int idle_cycles;
    bit calm;

    feathered_ellipse_mask_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(pix_if.sink), .o_mask(mask_if.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && mask_if.valid && mask_if.ready) sb.check_mask(mask_if.mask_value,
            mask_if.inside_res);
        mask_if.ready <= i_rst_n && (calm || ($urandom_range(99) >= 13));
    end

    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (mask_if.valid && mask_if.ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [12:0] d);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= d;
        @(posedge i_clk);
        sb.set_reg(idx, d);
    endtask

    task automatic set_box(int l, int t, int r, int b, int f);
        write_reg(REG_BOX_LEFT, l[12:0]);
        write_reg(REG_BOX_TOP, t[12:0]);
        write_reg(REG_BOX_RIGHT, r[12:0]);
        write_reg(REG_BOX_BOTTOM, b[12:0]);
        write_reg(REG_FEATHER, f[12:0]);
        i_cfg_we <= 0;
    endtask

    task automatic send_pixel(logic [11:0] x, logic [11:0] y);
        while (!calm && $urandom_range(99) < 13) begin
            pix_if.valid <= 0;
            @(posedge i_clk);
        end
        pix_if.valid <= 1; pix_if.pixel_x <= x; pix_if.pixel_y <= y;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        sb.note_pixel(x, y);
    endtask

    task automatic drain();
        pix_if.valid <= 0;
        @(posedge i_clk);
        while (sb.exp_mask.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic random_phase(int n, int l, int t, int r, int b);
        int x, y, xl, xh, yl, yh;
        xl = (l < r ? l : r) - 4; xh = (l < r ? r : l) + 4;
        yl = (t < b ? t : b) - 4; yh = (t < b ? b : t) + 4;
        if (xl < 0) xl = 0; if (yl < 0) yl = 0;
        if (xh > 4095) xh = 4095; if (yh > 4095) yh = 4095;
        if (xl > xh) xl = xh; if (yl > yh) yl = yh;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 8) begin
                x = $urandom_range(xh, xl); y = $urandom_range(yh, yl);
            end else begin
                x = $urandom_range(4095); y = $urandom_range(4095);
            end
            send_pixel(x[11:0], y[11:0]);
        end
        drain();
    endtask

    initial begin
        int l, t, r, b;
        sb = new();
        calm = 0;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = 0; i_cfg_data = 0;
        pix_if.valid = 0; pix_if.pixel_x = 0; pix_if.pixel_y = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // reset box: degenerate at origin
        send_pixel(0, 0); send_pixel(1, 1); send_pixel(2, 2); send_pixel(4095, 4095);
        drain();
        set_box(100, 100, 20, 40, 4095);
        send_pixel(60, 70); send_pixel(20, 70); send_pixel(100, 70);
        send_pixel(60, 40); send_pixel(61, 45); send_pixel(0, 0);
        drain();
        // tiny feather with large radii
        set_box(0, 0, 4095, 4095, 1);
        send_pixel(2047, 2047); send_pixel(0, 2047); send_pixel(4095, 4095);
        send_pixel(4094, 2047);
        drain();
        set_box(-4096, -4096, 4095, 4095, 4095);
        send_pixel(0, 0); send_pixel(4095, 0); send_pixel(0, 4095);
        send_pixel(2047, 4095); send_pixel(4095, 4095);
        drain();
        write_reg(3'd5, 13'h1fff);
        write_reg(3'd7, 13'h0aaa);
        set_box(500, 500, 500, 501, 0);
        send_pixel(501, 501); send_pixel(500, 500); send_pixel(502, 501);
        drain();
        for (int ph = 0; ph < 9; ph++) begin
            l = $urandom_range(600); t = $urandom_range(600);
            r = l + $urandom_range(200) - 20; b = t + $urandom_range(200) - 20;
            set_box(l, t, r, b, ph < 3 ? $urandom_range(4095) : $urandom_range(60));
            calm = (ph == 4);
            random_phase(100, l, t, r, b);
        end
        calm = 0;
        set_box(-4096, 4095, 4095, -4096, $urandom_range(4095));
        random_phase(60, 0, 0, 4095, 4095);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
